FILE: hdl/rtm_pkg.sv
// ----------------------------------------------------------------------------
// rtm_pkg
// Shared widths and constants for the Reinhard tone map pipeline.
// ----------------------------------------------------------------------------
package rtm_pkg;

	localparam int CH_W          = 32;
	localparam int GAIN_W        = 24;
	localparam int GAIN_FRAC     = 16;
	localparam int Y_W           = CH_W + GAIN_W;
	localparam int Q_W           = 8;
	localparam int FRAC_BITS_DEF = 16;
	localparam int PREP_STAGES   = 2;
	localparam int LATENCY       = PREP_STAGES + Q_W;

	localparam logic [GAIN_W-1:0] GAIN_RESET  = 24'h010000;
	localparam logic [Q_W-1:0]    ALPHA_VALUE = 8'hFF;

endpackage

FILE: hdl/reinhard_tone_map_rgba8.sv
// ----------------------------------------------------------------------------
// reinhard_tone_map_rgba8
// Reinhard tone map with exposure gain, one HDR pixel in, one RGBA8 word out.
//
// channel   signals                                   direction
// input     start, busy, red_in, green_in, blue_in,   in (busy out)
//           last_in
// result    done, pixel_word, last_out                out
// config    cfg_valid, cfg_ready, exposure_gain       in (cfg_ready out)
//
// one pixel per clock; each result passes through the multiply stage,
// the prep stage and eight divider stages
// busy and cfg_ready are constant: the pipeline never stalls
// reset clears the valid pipeline and loads the gain with 1.0
// ----------------------------------------------------------------------------
module reinhard_tone_map_rgba8 #(
	parameter int FRAC_BITS = rtm_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [rtm_pkg::CH_W-1:0]   red_in,
	input  logic [rtm_pkg::CH_W-1:0]   green_in,
	input  logic [rtm_pkg::CH_W-1:0]   blue_in,
	input  logic                       last_in,
	output logic                       done,
	output logic [rtm_pkg::CH_W-1:0]   pixel_word,
	output logic                       last_out,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [rtm_pkg::GAIN_W-1:0] exposure_gain
);

	logic [rtm_pkg::GAIN_W-1:0]  gain_q;
	logic [rtm_pkg::LATENCY-1:0] vld_q;
	logic [rtm_pkg::LATENCY-1:0] last_q;
	logic [rtm_pkg::Q_W-1:0]     red_lvl;
	logic [rtm_pkg::Q_W-1:0]     green_lvl;
	logic [rtm_pkg::Q_W-1:0]     blue_lvl;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= rtm_pkg::GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gain_q <= exposure_gain;
		end
	end

	// valid bits travel alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[rtm_pkg::LATENCY-2:0], start && !busy};
		end
	end

	always_ff @(posedge clk) begin
		last_q <= {last_q[rtm_pkg::LATENCY-2:0], last_in};
	end

	rtm_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
		.clk   (clk),
		.chan  (red_in),
		.gain  (gain_q),
		.level (red_lvl)
	);

	rtm_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
		.clk   (clk),
		.chan  (green_in),
		.gain  (gain_q),
		.level (green_lvl)
	);

	rtm_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
		.clk   (clk),
		.chan  (blue_in),
		.gain  (gain_q),
		.level (blue_lvl)
	);

	assign done       = vld_q[rtm_pkg::LATENCY-1];
	assign last_out   = last_q[rtm_pkg::LATENCY-1];
	assign pixel_word = {red_lvl, green_lvl, blue_lvl, rtm_pkg::ALPHA_VALUE};

endmodule

FILE: hdl/rtm_div_step.sv
// ----------------------------------------------------------------------------
// rtm_div_step
// One registered restoring division stage: retires one quotient bit.
// ----------------------------------------------------------------------------
module rtm_div_step #(
	parameter int R_W   = 66,
	parameter int DD_W  = 58,
	parameter int SHIFT = 0
) (
	input  logic                     clk,
	input  logic [R_W-1:0]           rem_in,
	input  logic [DD_W-1:0]          den_in,
	input  logic [rtm_pkg::Q_W-1:0]  quo_in,
	output logic [R_W-1:0]           rem_out,
	output logic [DD_W-1:0]          den_out,
	output logic [rtm_pkg::Q_W-1:0]  quo_out
);

	logic [R_W-1:0] den_sh;
	logic [R_W-1:0] diff;
	logic           take;

	assign den_sh = {{(R_W-DD_W){1'b0}}, den_in} << SHIFT;
	assign take   = rem_in >= den_sh;
	assign diff   = rem_in - den_sh;

	always_ff @(posedge clk) begin
		rem_out <= take ? diff : rem_in;
		den_out <= den_in;
		quo_out <= {quo_in[rtm_pkg::Q_W-2:0], take};
	end

endmodule

FILE: hdl/rtm_chan.sv
// ----------------------------------------------------------------------------
// rtm_chan
// One color channel: exposure multiply, Reinhard numerator and denominator,
// then an eight stage divider giving round(255 * y / (y + 1)).
// ----------------------------------------------------------------------------
module rtm_chan #(
	parameter int FRAC_BITS = rtm_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic [rtm_pkg::CH_W-1:0]   chan,
	input  logic [rtm_pkg::GAIN_W-1:0] gain,
	output logic [rtm_pkg::Q_W-1:0]    level
);

	localparam int ONE_SH = FRAC_BITS + rtm_pkg::GAIN_FRAC;
	localparam int D_W    = ((rtm_pkg::Y_W > ONE_SH + 1) ? rtm_pkg::Y_W : ONE_SH + 1) + 1;
	localparam int DD_W   = D_W + 1;
	localparam int R_W    = DD_W + rtm_pkg::Q_W;
	localparam logic [R_W-1:0] ONE_R = {{(R_W-1){1'b0}}, 1'b1} << ONE_SH;

	logic [rtm_pkg::Y_W-1:0] y_s1;
	logic [R_W-1:0]          y_ext;
	logic [R_W-1:0]          num;
	logic [R_W-1:0]          den2;

	logic [R_W-1:0]          rem_s [0:rtm_pkg::Q_W];
	logic [DD_W-1:0]         den_s [0:rtm_pkg::Q_W];
	logic [rtm_pkg::Q_W-1:0] quo_s [0:rtm_pkg::Q_W];

	// y = c * g
	always_ff @(posedge clk) begin
		y_s1 <= chan * gain;
	end

	// numerator 510*y + d = 511*y + one, divisor 2*d
	assign y_ext = {{(R_W-rtm_pkg::Y_W){1'b0}}, y_s1};
	assign num   = (y_ext << 9) - y_ext + ONE_R;
	assign den2  = (y_ext << 1) + (ONE_R << 1);

	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den2[DD_W-1:0];
		quo_s[0] <= '0;
	end

	for (genvar k = 0; k < rtm_pkg::Q_W; k++) begin : g_div
		rtm_div_step #(
			.R_W   (R_W),
			.DD_W  (DD_W),
			.SHIFT (rtm_pkg::Q_W - 1 - k)
		) u_step (
			.clk     (clk),
			.rem_in  (rem_s[k]),
			.den_in  (den_s[k]),
			.quo_in  (quo_s[k]),
			.rem_out (rem_s[k+1]),
			.den_out (den_s[k+1]),
			.quo_out (quo_s[k+1])
		);
	end

	assign level = quo_s[rtm_pkg::Q_W];

endmodule
